>>> rtl/llex_pkg.sv
// Package for the Lisp token lexer: token kinds, character codes, run classes and helpers.
// It depends on nothing; every module of the lexer and its test files import it.
package llex_pkg;

  typedef enum logic [1:0] {
    CLS_MINUS = 2'd0,
    CLS_INT   = 2'd1,
    CLS_FLOAT = 2'd2,
    CLS_SYM   = 2'd3
  } cls_e;

  typedef enum logic {
    SLOT_FIRST  = 1'b0,
    SLOT_SECOND = 1'b1
  } slot_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [1:0] KIND_INT    = 2'd0;
  localparam logic [1:0] KIND_FLOAT  = 2'd1;
  localparam logic [1:0] KIND_SYMBOL = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_NEAR_MAX = 32'hFFFF_FFFE;
  localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
  localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;
  localparam logic signed [15:0] DEPTH_ONE = 16'sh0001;
  localparam logic signed [15:0] DEPTH_TWO = 16'sh0002;

  function automatic logic is_run_byte(input logic [7:0] c);
    logic r;
    r = ((c >= CH_PLUS) && (c <= CH_EQUAL)) || (c == CH_STAR) ||
        ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    return r;
  endfunction

  function automatic cls_e next_class(input cls_e s, input logic [7:0] c);
    logic dig;
    cls_e r;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    unique case (s)
      CLS_MINUS: begin
        if (c == CH_MINUS) r = CLS_MINUS;
        else if (dig) r = CLS_INT;
        else if (c == CH_DOT) r = CLS_FLOAT;
        else r = CLS_SYM;
      end
      CLS_INT: begin
        if (dig) r = CLS_INT;
        else if (c == CH_DOT) r = CLS_FLOAT;
        else r = CLS_SYM;
      end
      CLS_FLOAT: r = dig ? CLS_FLOAT : CLS_SYM;
      default: r = CLS_SYM;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] kind_of(input cls_e s);
    logic [1:0] k;
    unique case (s)
      CLS_INT:   k = KIND_INT;
      CLS_FLOAT: k = KIND_FLOAT;
      default:   k = KIND_SYMBOL;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/llex_in_if.sv
// Input channel of the lexer: one source byte and an end-of-source flag per transaction.
// Stands alone; used by the front stage and the top level.
interface llex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source (output valid, output ch, output end_of_source, input ready);
  modport sink (input valid, input ch, input end_of_source, output ready);
endinterface

>>> rtl/llex_cfg_if.sv
// Configuration write channel of the lexer, carrying the comment stripping bit.
// Stands alone; used by the front stage and the top level.
interface llex_cfg_if;
  logic valid;
  logic ready;
  logic strip_comments;

  modport source (output valid, output strip_comments, input ready);
  modport sink (input valid, input strip_comments, output ready);
endinterface

>>> rtl/llex_out_if.sv
// Output channel of the lexer: one token record per transaction.
// Widths follow the line and column parameters of the top level.
interface llex_out_if #(
  parameter int LINE_W = 16,
  parameter int COL_W  = 12,
  parameter int END_W  = 13
);
  logic              valid;
  logic              ready;
  logic [1:0]        token_kind;
  logic [LINE_W-1:0] line_index;
  logic [COL_W-1:0]  start_column;
  logic [END_W-1:0]  end_column;
  logic [31:0]       token_number;
  logic              last_of_item;

  modport source (output valid, output token_kind, output line_index, output start_column,
                  output end_column, output token_number, output last_of_item, input ready);
  modport sink (input valid, input token_kind, input line_index, input start_column,
                input end_column, input token_number, input last_of_item, output ready);
endinterface

>>> rtl/llex_front.sv
// Front stage of the lexer: scans one byte per cycle while the queue is not full, tracks run, line,
// column, id and depth state, and writes up to two token records per byte into the queue. Uses llex_pkg.
module llex_front #(
  parameter int LINE_LEN   = 4096,
  parameter int LINE_LIMIT = 65536,
  parameter int LINE_W     = 16,
  parameter int COL_W      = 12,
  parameter int END_W      = 13,
  parameter int REC_W      = 77
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  llex_in_if.sink                in_chan,
  llex_cfg_if.sink               cfg_chan,
  input  llex_pkg::q_status_t    q_status_i,
  output logic                   push_o,
  output logic [2*REC_W-1:0]     push_data_o
);
  import llex_pkg::*;

  logic                     strip_q;
  logic                     in_run_q, in_run_d;
  logic [COL_W-1:0]         run_start_q, run_start_d;
  cls_e                     class_q, class_d;
  logic [END_W-1:0]         column_q, column_d;
  logic [LINE_W-1:0]        line_count_q, line_count_d;
  logic                     nonblank_q, nonblank_d;
  logic [31:0]              next_id_q, next_id_d;
  logic signed [15:0]       depth_q, depth_d;
  logic                     in_comment_q, in_comment_d;

  logic             accept;
  logic [7:0]       c;
  logic             eos, run_b, tok1, is_open, is_close, boundary;
  logic             flush, drop0, drop1, keep0, keep1;
  cls_e             cls_base, cls_new, flush_cls;
  logic [COL_W-1:0] start_cur, run_s, flush_start;
  logic [END_W-1:0] col_inc, flush_end, paren_end;
  logic [31:0]      id_p1, id_p2, id1;
  logic [REC_W-1:0] rec0, rec1;

  assign accept = in_chan.valid & in_chan.ready;
  assign in_chan.ready = ~q_status_i.full;
  assign cfg_chan.ready = 1'b1;
  assign c = in_chan.ch;
  assign eos = in_chan.end_of_source;

  always_comb begin
    run_b = is_run_byte(c);
    tok1 = ~run_b & ((c == CH_LPAR) | (c == CH_RPAR) | (c == CH_APOS));
    is_open = tok1 & (c == CH_LPAR);
    is_close = tok1 & (c == CH_RPAR);

    start_cur = (column_q >= END_W'(LINE_LEN - 1)) ? COL_W'(LINE_LEN - 1)
                                                   : column_q[COL_W-1:0];
    col_inc = (column_q != END_W'(LINE_LEN)) ? column_q + END_W'(1) : column_q;
    paren_end = col_inc;

    cls_base = in_run_q ? class_q : CLS_MINUS;
    cls_new = next_class(cls_base, c);
    run_s = in_run_q ? run_start_q : start_cur;

    flush = run_b ? eos : in_run_q;
    flush_cls = run_b ? cls_new : class_q;
    flush_start = run_b ? run_s : run_start_q;
    flush_end = run_b ? col_inc : column_q;

    id_p1 = (next_id_q != ID_MAX) ? next_id_q + 32'd1 : ID_MAX;
    id_p2 = (next_id_q >= ID_NEAR_MAX) ? ID_MAX : next_id_q + 32'd2;
    id1 = flush ? id_p1 : next_id_q;
    if (flush & tok1) next_id_d = id_p2;
    else if (flush | tok1) next_id_d = id_p1;
    else next_id_d = next_id_q;

    boundary = (is_open & (depth_q == DEPTH_ONE)) | (is_close & (depth_q == DEPTH_TWO));
    depth_d = depth_q;
    if (is_open && depth_q != DEPTH_MAX) depth_d = depth_q + 16'sd1;
    else if (is_close && depth_q != DEPTH_MIN) depth_d = depth_q - 16'sd1;
    in_comment_d = in_comment_q ^ boundary;

    drop0 = strip_q & in_comment_q;
    drop1 = boundary ? strip_q : (strip_q & in_comment_q);
    keep0 = flush & ~drop0;
    keep1 = tok1 & ~drop1;

    rec0 = {keep0, ~keep1, kind_of(flush_cls), line_count_q, flush_start, flush_end,
            next_id_q};
    rec1 = {keep1, 1'b1, KIND_SYMBOL, line_count_q, start_cur, paren_end, id1};

    nonblank_d = nonblank_q | ((c != CH_SPACE) & (c != CH_TAB) & (c != CH_LF));
    line_count_d = line_count_q;
    if (c == CH_LF) begin
      nonblank_d = 1'b0;
      if (nonblank_q && line_count_q != LINE_W'(LINE_LIMIT - 1)) begin
        line_count_d = line_count_q + LINE_W'(1);
      end
    end

    if (!run_b && c == CH_LF) column_d = '0;
    else column_d = col_inc;

    in_run_d = run_b & ~eos;
    class_d = (run_b && !eos) ? cls_new : CLS_MINUS;
    run_start_d = run_b ? run_s : run_start_q;
  end

  assign push_o = accept & (keep0 | keep1);
  assign push_data_o = {rec1, rec0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b1;
    end else if (cfg_chan.valid) begin
      strip_q <= cfg_chan.strip_comments;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q     <= 1'b0;
      run_start_q  <= '0;
      class_q      <= CLS_MINUS;
      column_q     <= '0;
      line_count_q <= '0;
      nonblank_q   <= 1'b0;
      next_id_q    <= 32'd1;
      depth_q      <= DEPTH_ONE;
      in_comment_q <= 1'b0;
    end else if (accept) begin
      in_run_q     <= in_run_d;
      run_start_q  <= run_start_d;
      class_q      <= class_d;
      column_q     <= column_d;
      line_count_q <= line_count_d;
      nonblank_q   <= nonblank_d;
      next_id_q    <= next_id_d;
      depth_q      <= depth_d;
      in_comment_q <= in_comment_d;
    end
  end

endmodule

>>> rtl/llex_queue.sv
// Short first-in first-out queue of token record pairs between the front and back stages.
// Uses llex_pkg for the status struct.
module llex_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 154
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    data_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    data_o,
  output llex_pkg::q_status_t status_o
);
  import llex_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) count_d = count_q + CNT_W'(1);
    else if (!push_i && pop_i) count_d = count_q - CNT_W'(1);
  end

  assign status_o.full = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full || pop_i)
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("Queue read while empty.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("Queue count beyond its depth.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("Queue count did not follow a write.");

endmodule

>>> rtl/llex_back.sv
// Back stage of the lexer: takes record pairs from the queue and hands out one token per
// transaction through an output register. Uses llex_pkg.
module llex_back #(
  parameter int LINE_W = 16,
  parameter int COL_W  = 12,
  parameter int END_W  = 13,
  parameter int REC_W  = 77
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2*REC_W-1:0]  head_i,
  input  llex_pkg::q_status_t q_status_i,
  output logic                pop_o,
  llex_out_if.source          out_chan
);
  import llex_pkg::*;

  slot_e slot_q, slot_d;
  logic  valid_q, valid_d;

  logic              v0, l0, v1, l1;
  logic [1:0]        k0, k1;
  logic [LINE_W-1:0] ln0, ln1;
  logic [COL_W-1:0]  s0, s1;
  logic [END_W-1:0]  e0, e1;
  logic [31:0]       id0, id1;

  logic              load, use_second, more;
  logic [1:0]        kind_q, kind_sel;
  logic [LINE_W-1:0] line_q, line_sel;
  logic [COL_W-1:0]  start_q, start_sel;
  logic [END_W-1:0]  end_q, end_sel;
  logic [31:0]       id_q, id_sel;
  logic              last_q, last_sel;

  assign {v0, l0, k0, ln0, s0, e0, id0} = head_i[REC_W-1:0];
  assign {v1, l1, k1, ln1, s1, e1, id1} = head_i[2*REC_W-1:REC_W];

  assign load = ~q_status_i.empty & (~valid_q | out_chan.ready);
  assign use_second = (slot_q == SLOT_SECOND) | ~v0;
  assign more = ~use_second & v1;

  always_comb begin
    slot_d = slot_q;
    if (load) begin
      slot_d = more ? SLOT_SECOND : SLOT_FIRST;
    end
  end

  always_comb begin
    pop_o = load & ~more;
    kind_sel = use_second ? k1 : k0;
    line_sel = use_second ? ln1 : ln0;
    start_sel = use_second ? s1 : s0;
    end_sel = use_second ? e1 : e0;
    id_sel = use_second ? id1 : id0;
    last_sel = use_second ? l1 : l0;
    if (load) valid_d = 1'b1;
    else if (out_chan.ready) valid_d = 1'b0;
    else valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SLOT_FIRST;
      valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_sel;
      line_q  <= line_sel;
      start_q <= start_sel;
      end_q   <= end_sel;
      id_q    <= id_sel;
      last_q  <= last_sel;
    end
  end

  assign out_chan.valid = valid_q;
  assign out_chan.token_kind = kind_q;
  assign out_chan.line_index = line_q;
  assign out_chan.start_column = start_q;
  assign out_chan.end_column = end_q;
  assign out_chan.token_number = id_q;
  assign out_chan.last_of_item = last_q;

endmodule

>>> rtl/lisp_token_lexer_top.sv
// Lisp token lexer: a token's record enters the queue when its byte is accepted and is then loaded
// into the output register. Throughput is one byte per cycle while the queue is not full; a byte
// that yields two tokens makes two transactions; the four-entry record queue absorbs bursts and stalls.
// Reset clears all scan state at once: stripping on, depth one, token ids from one, no clearing pass.
// Uses llex_pkg, the three channel interfaces, llex_front, llex_queue and llex_back.
module lisp_token_lexer_top #(
  parameter int LINE_LEN   = 4096,
  parameter int LINE_LIMIT = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  llex_in_if.sink    in_chan,
  llex_cfg_if.sink   cfg_chan,
  llex_out_if.source out_chan
);
  import llex_pkg::*;

  localparam int LINE_W = $clog2(LINE_LIMIT);
  localparam int COL_W  = $clog2(LINE_LEN);
  localparam int END_W  = $clog2(LINE_LEN + 1);
  localparam int REC_W  = 2 + 2 + LINE_W + COL_W + END_W + 32;
  localparam int Q_DEPTH = 4;

  q_status_t            q_status;
  logic                 push, pop;
  logic [2*REC_W-1:0]   push_data, head;

  llex_front #(
    .LINE_LEN  (LINE_LEN),
    .LINE_LIMIT(LINE_LIMIT),
    .LINE_W    (LINE_W),
    .COL_W     (COL_W),
    .END_W     (END_W),
    .REC_W     (REC_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .q_status_i (q_status),
    .push_o     (push),
    .push_data_o(push_data)
  );

  llex_queue #(
    .DEPTH(Q_DEPTH),
    .WIDTH(2 * REC_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (head),
    .status_o(q_status)
  );

  llex_back #(
    .LINE_W(LINE_W),
    .COL_W (COL_W),
    .END_W (END_W),
    .REC_W (REC_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_status_i(q_status),
    .pop_o     (pop),
    .out_chan  (out_chan)
  );

endmodule

>>> test/llex_token_checker.sv
// Token checker for the Lisp token lexer: follows the byte, configuration and token channels,
// works out the expected token records itself and compares every token transaction with them.
// Depends on llex_pkg for the run classes, token kinds, character codes and limits.
module llex_token_checker
  import llex_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_ch_i,
  input  logic        in_eos_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_strip_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  out_kind_i,
  input  logic [15:0] out_line_i,
  input  logic [11:0] out_start_i,
  input  logic [12:0] out_end_i,
  input  logic [31:0] out_number_i,
  input  logic        out_last_i,
  output int          error_count_o,
  output int          tokens_owed_o
);

  localparam int LineLen   = 4096;
  localparam int LineLimit = 65536;

  typedef enum logic [1:0] {
    PAREN_NONE,
    PAREN_OPEN,
    PAREN_CLOSE
  } paren_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] line;
    logic [11:0] start_col;
    logic [12:0] end_col;
    logic [31:0] number;
    logic        last;
  } token_t;

  token_t      expected_tokens[$];
  logic        strip_on = 1'b1;
  logic        run_open = 1'b0;
  int          run_first_col = 0;
  cls_e        run_class = CLS_MINUS;
  int          cur_col = 0;
  int          nonblank_lines = 0;
  logic        line_has_text = 1'b0;
  logic [31:0] next_number = 32'd1;
  int          depth = 1;
  logic        in_region = 1'b0;
  int          step_tokens = 0;
  int          errors = 0;

  function automatic logic word_byte(input logic [7:0] c);
    return ((c >= CH_PLUS) && (c <= CH_EQUAL)) || (c == CH_STAR) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

  function automatic cls_e advance_class(input cls_e s, input logic [7:0] c);
    logic digit;
    cls_e r;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    r = CLS_SYM;
    case (s)
      CLS_MINUS: begin
        if (c == CH_MINUS) r = CLS_MINUS;
        else if (digit) r = CLS_INT;
        else if (c == CH_DOT) r = CLS_FLOAT;
      end
      CLS_INT: begin
        if (digit) r = CLS_INT;
        else if (c == CH_DOT) r = CLS_FLOAT;
      end
      CLS_FLOAT: begin
        if (digit) r = CLS_FLOAT;
      end
      default: r = CLS_SYM;
    endcase
    return r;
  endfunction

  function automatic int clip_start(input int c);
    return (c > LineLen - 1) ? LineLen - 1 : c;
  endfunction

  function automatic int clip_end(input int c);
    return (c > LineLen) ? LineLen : c;
  endfunction

  task automatic issue_token(input logic [1:0] kind, input int first, input int stop,
                             input paren_e paren);
    token_t t;
    logic boundary;
    logic dropped;
    t.kind = kind;
    t.line = nonblank_lines[15:0];
    t.start_col = first[11:0];
    t.end_col = stop[12:0];
    t.number = next_number;
    t.last = 1'b0;
    boundary = 1'b0;
    if (next_number != ID_MAX) next_number++;
    if (paren == PAREN_OPEN) begin
      boundary = (depth == 1);
      if (depth < int'(DEPTH_MAX)) depth++;
    end else if (paren == PAREN_CLOSE) begin
      if (depth > int'(DEPTH_MIN)) depth--;
      boundary = (depth == 1);
    end
    if (boundary) begin
      in_region = !in_region;
      dropped = strip_on;
    end else begin
      dropped = strip_on && in_region;
    end
    if (!dropped && step_tokens < 2) begin
      expected_tokens.push_back(t);
      step_tokens++;
    end
  endtask

  task automatic close_run(input int stop);
    logic [1:0] kind;
    if (run_open) begin
      run_open = 1'b0;
      case (run_class)
        CLS_INT:   kind = KIND_INT;
        CLS_FLOAT: kind = KIND_FLOAT;
        default:   kind = KIND_SYMBOL;
      endcase
      run_class = CLS_MINUS;
      issue_token(kind, run_first_col, clip_end(stop), PAREN_NONE);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic eos);
    token_t t;
    step_tokens = 0;
    if (c != CH_SPACE && c != CH_TAB && c != CH_LF) line_has_text = 1'b1;
    if (word_byte(c)) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_first_col = clip_start(cur_col);
        run_class = CLS_MINUS;
      end
      run_class = advance_class(run_class, c);
      if (cur_col < LineLen) cur_col++;
      if (eos) close_run(cur_col);
    end else begin
      close_run(cur_col);
      if (c == CH_LPAR) begin
        issue_token(KIND_SYMBOL, clip_start(cur_col), clip_end(cur_col + 1), PAREN_OPEN);
      end else if (c == CH_RPAR) begin
        issue_token(KIND_SYMBOL, clip_start(cur_col), clip_end(cur_col + 1), PAREN_CLOSE);
      end else if (c == CH_APOS) begin
        issue_token(KIND_SYMBOL, clip_start(cur_col), clip_end(cur_col + 1), PAREN_NONE);
      end
      if (c == CH_LF) begin
        if (line_has_text && nonblank_lines < LineLimit - 1) nonblank_lines++;
        line_has_text = 1'b0;
        cur_col = 0;
      end else if (cur_col < LineLen) begin
        cur_col++;
      end
    end
    if (step_tokens > 0) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  task automatic check_token();
    token_t want;
    token_t got;
    got.kind = out_kind_i;
    got.line = out_line_i;
    got.start_col = out_start_i;
    got.end_col = out_end_i;
    got.number = out_number_i;
    got.last = out_last_i;
    if (expected_tokens.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected token: kind %0d line %0d cols %0d-%0d id %0d last %0b",
                 got.kind, got.line, got.start_col, got.end_col, got.number, got.last);
      end
    end else begin
      want = expected_tokens.pop_front();
      if (want != got) begin
        errors++;
        if (errors <= 10) begin
          $display("token mismatch: expected kind %0d line %0d cols %0d-%0d id %0d last %0b",
                   want.kind, want.line, want.start_col, want.end_col, want.number, want.last);
          $display("                got      kind %0d line %0d cols %0d-%0d id %0d last %0b",
                   got.kind, got.line, got.start_col, got.end_col, got.number, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_tokens.delete();
      strip_on = 1'b1;
      run_open = 1'b0;
      run_first_col = 0;
      run_class = CLS_MINUS;
      cur_col = 0;
      nonblank_lines = 0;
      line_has_text = 1'b0;
      next_number = 32'd1;
      depth = 1;
      in_region = 1'b0;
      tokens_owed_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) strip_on = cfg_strip_i;
      if (in_valid_i && in_ready_i) lex_byte(in_ch_i, in_eos_i);
      if (out_valid_i && out_ready_i) check_token();
      tokens_owed_o <= expected_tokens.size();
    end
    error_count_o <= errors;
  end

endmodule

>>> test/tb_lisp_token_lexer_top.sv
// Testbench top for the Lisp token lexer: drives source bytes, comment stripping writes and
// output back-pressure, and gives the verdict from the count kept by llex_token_checker.
// Depends on llex_pkg, the three lexer channel interfaces and lisp_token_lexer_top.
module tb_lisp_token_lexer_top;
  import llex_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic rx_ready = 1'b0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   bytes_sent = 0;
  int   lone_opens = 0;
  int   error_count;
  int   tokens_owed;

  llex_in_if  in_chan ();
  llex_cfg_if cfg_chan ();
  llex_out_if out_chan ();

  assign out_chan.ready = rx_ready;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rx_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  lisp_token_lexer_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .out_chan (out_chan)
  );

  llex_token_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_chan.valid),
    .in_ready_i    (in_chan.ready),
    .in_ch_i       (in_chan.ch),
    .in_eos_i      (in_chan.end_of_source),
    .cfg_valid_i   (cfg_chan.valid),
    .cfg_ready_i   (cfg_chan.ready),
    .cfg_strip_i   (cfg_chan.strip_comments),
    .out_valid_i   (out_chan.valid),
    .out_ready_i   (out_chan.ready),
    .out_kind_i    (out_chan.token_kind),
    .out_line_i    (out_chan.line_index),
    .out_start_i   (out_chan.start_column),
    .out_end_i     (out_chan.end_column),
    .out_number_i  (out_chan.token_number),
    .out_last_i    (out_chan.last_of_item),
    .error_count_o (error_count),
    .tokens_owed_o (tokens_owed)
  );

  function automatic logic maybe_eos();
    return $urandom_range(0, 99) < 3;
  endfunction

  function automatic logic [7:0] any_run_byte();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = CH_LO_A + 8'($urandom_range(0, 25));
      1: c = CH_UP_A + 8'($urandom_range(0, 25));
      2: c = CH_PLUS + 8'($urandom_range(0, 18));
      default: c = CH_STAR;
    endcase
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eos);
    while ($urandom_range(0, 99) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch <= c;
    in_chan.end_of_source <= eos;
    do @(posedge clk_i); while (!in_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk_i); while (tokens_owed != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_strip(input logic strip);
    cfg_chan.valid <= 1'b1;
    cfg_chan.strip_comments <= strip;
    do @(posedge clk_i); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic send_word();
    case ($urandom_range(0, 15))
      0, 1: begin
        repeat ($urandom_range(0, 2)) send_byte(CH_MINUS, maybe_eos());
        repeat ($urandom_range(1, 4)) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), maybe_eos());
      end
      2, 3: begin
        repeat ($urandom_range(0, 1)) send_byte(CH_MINUS, maybe_eos());
        repeat ($urandom_range(0, 3)) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), maybe_eos());
        send_byte(CH_DOT, maybe_eos());
        repeat ($urandom_range(0, 3)) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), maybe_eos());
      end
      4, 5, 12, 13: begin
        repeat ($urandom_range(1, 6)) send_byte(any_run_byte(), maybe_eos());
      end
      6: send_byte(CH_APOS, maybe_eos());
      7, 8, 14: begin
        send_byte(CH_LPAR, 1'b0);
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(1, 4)) send_byte(any_run_byte(), 1'b0);
          send_byte(CH_SPACE, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_byte(CH_LPAR, 1'b0);
          send_byte(any_run_byte(), 1'b0);
          send_byte(CH_RPAR, 1'b0);
        end
        send_byte(CH_RPAR, maybe_eos());
      end
      9: begin
        if ((lone_opens > 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 1) == 0) begin
          send_byte(CH_RPAR, maybe_eos());
          lone_opens--;
        end else begin
          send_byte(CH_LPAR, maybe_eos());
          lone_opens++;
        end
      end
      10: send_byte(8'($urandom_range(0, 255)), maybe_eos());
      default: begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) begin
            send_byte(($urandom_range(0, 1) == 0) ? CH_TAB : CH_SPACE, 1'b0);
          end
          send_byte(CH_LF, maybe_eos());
        end
      end
    endcase
    case ($urandom_range(0, 9))
      7: send_byte(CH_TAB, maybe_eos());
      8: send_byte(CH_LF, maybe_eos());
      9: ;
      default: send_byte(CH_SPACE, maybe_eos());
    endcase
  endtask

  task automatic random_stream(input int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_word();
  endtask

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_chan.valid <= 1'b0;
    in_chan.ch <= 8'h00;
    in_chan.end_of_source <= 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.strip_comments <= 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 20;
    recv_idle = 57;
    write_strip(1'b1);
    send_text("--7\t1. .5\n \n-+=*'(Zz)");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_RPAR, 1'b0);
    send_byte(CH_LPAR, 1'b0);
    send_byte(CH_NINE, 1'b1);
    random_stream(140);
    drain();
    random_stream(140);

    drain();
    write_strip(1'b0);
    send_idle = 57;
    recv_idle = 20;
    random_stream(280);

    drain();
    write_strip(1'b1);
    send_idle = 0;
    recv_idle = 0;
    random_stream(160);
    drain();
    write_strip(1'b0);
    random_stream(120);

    drain();
    write_strip(1'b1);
    send_text(" 7 '(x)\n-1.5 q");
    send_byte(CH_APOS, 1'b1);

    drain();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
